@@ hw/rtl/pca_pkg.sv @@
package pca_pkg;

	// Request functions.
	localparam logic [1:0] FN_ALLOC = 2'd0;
	localparam logic [1:0] FN_FREE  = 2'd1;
	localparam logic [1:0] FN_QUERY = 2'd2;

	// Result status codes.
	localparam logic [2:0] ST_EXACT   = 3'd0;
	localparam logic [2:0] ST_ADDED   = 3'd1;
	localparam logic [2:0] ST_NEAREST = 3'd2;
	localparam logic [2:0] ST_FREED   = 3'd3;
	localparam logic [2:0] ST_READ    = 3'd4;
	localparam logic [2:0] ST_FAILED  = 3'd5;

	// Result selection handed from the controller to the datapath.
	localparam logic [1:0] SEL_FAIL  = 2'd0;
	localparam logic [1:0] SEL_FREE  = 2'd1;
	localparam logic [1:0] SEL_READ  = 2'd2;
	localparam logic [1:0] SEL_ALLOC = 2'd3;

	localparam int DIST_W = 18;
	localparam logic [DIST_W-1:0] NEAR_RESET = 18'd128;

	typedef struct packed {
		logic [15:0] r;
		logic [15:0] g;
		logic [15:0] b;
	} rgb_t;

	localparam rgb_t LOW_DEF [0:9] = '{
		'{16'h0000, 16'h0000, 16'h0000}, '{16'h8000, 16'h0000, 16'h0000},
		'{16'h0000, 16'h8000, 16'h0000}, '{16'h8000, 16'h8000, 16'h0000},
		'{16'h0000, 16'h0000, 16'h8000}, '{16'h8000, 16'h0000, 16'h8000},
		'{16'h0000, 16'h8000, 16'h8000}, '{16'hc000, 16'hc000, 16'hc000},
		'{16'hc000, 16'hdc00, 16'hc000}, '{16'ha600, 16'hca00, 16'hf000}
	};

	localparam rgb_t HIGH_DEF [0:9] = '{
		'{16'hff00, 16'hfb00, 16'hf000}, '{16'ha000, 16'ha000, 16'ha400},
		'{16'h8000, 16'h8000, 16'h8000}, '{16'hff00, 16'h0000, 16'h0000},
		'{16'h0000, 16'hff00, 16'h0000}, '{16'hff00, 16'hff00, 16'h0000},
		'{16'h0000, 16'h0000, 16'hff00}, '{16'hff00, 16'h0000, 16'hff00},
		'{16'h0000, 16'hff00, 16'hff00}, '{16'hff00, 16'hff00, 16'hff00}
	};

	typedef struct packed {
		logic       load;
		logic       scan_start;
		logic       scan_issue;
		logic       clr_step;
		logic       emit;
		logic [1:0] sel;
	} pca_cmd_t;

	typedef struct packed {
		logic       clr_done;
		logic       bad;
		logic [1:0] func;
		logic       scan_last;
		logic       busy;
		logic       out_free;
	} pca_sts_t;

	// Reset color of entry e in a palette of n entries; the top ten win on overlap.
	function automatic rgb_t default_rgb(input logic [9:0] e, input logic [9:0] n);
		rgb_t       c;
		logic [9:0] k;
		c = '0;
		k = e + 10'd10 - n;
		if (e < 10'd10) begin
			c = LOW_DEF[e[3:0]];
		end
		if ((e + 10'd10 >= n) && (e < n)) begin
			c = HIGH_DEF[k[3:0]];
		end
		return c;
	endfunction

	function automatic logic default_used(input logic [9:0] e, input logic [9:0] n);
		return (e < 10'd10) || ((e + 10'd10 >= n) && (e < n));
	endfunction

	function automatic logic [15:0] absdiff16(input logic [15:0] a, input logic [15:0] b);
		return (a > b) ? (a - b) : (b - a);
	endfunction

endpackage

@@ hw/rtl/pca_req_if.sv @@
interface pca_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  func;
	logic [1:0]  map_index;
	logic [7:0]  pixel_index;
	logic [15:0] req_red;
	logic [15:0] req_green;
	logic [15:0] req_blue;

	modport source (
		output valid, func, map_index, pixel_index, req_red, req_green, req_blue,
		input  ready
	);
	modport sink (
		input  valid, func, map_index, pixel_index, req_red, req_green, req_blue,
		output ready
	);
endinterface

@@ hw/rtl/pca_rsp_if.sv @@
interface pca_rsp_if;
	logic        valid;
	logic        ready;
	logic [2:0]  status;
	logic [7:0]  pixel;
	logic [15:0] out_red;
	logic [15:0] out_green;
	logic [15:0] out_blue;

	modport source (
		output valid, status, pixel, out_red, out_green, out_blue,
		input  ready
	);
	modport sink (
		input  valid, status, pixel, out_red, out_green, out_blue,
		output ready
	);
endinterface

@@ hw/rtl/pca_ctrl.sv @@
module pca_ctrl
	import pca_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  pca_sts_t sts,
	output pca_cmd_t cmd
);

	localparam logic [2:0] S_CLR   = 3'd0;
	localparam logic [2:0] S_IDLE  = 3'd1;
	localparam logic [2:0] S_DISP  = 3'd2;
	localparam logic [2:0] S_QRD   = 3'd3;
	localparam logic [2:0] S_SCAN  = 3'd4;
	localparam logic [2:0] S_DRAIN = 3'd5;
	localparam logic [2:0] S_EMIT  = 3'd6;

	logic [2:0] state_q, state_d;
	logic [1:0] sel_q, sel_d;

	always_comb begin
		state_d  = state_q;
		sel_d    = sel_q;
		in_ready = 1'b0;
		cmd      = '0;
		cmd.sel  = sel_q;
		case (state_q)
			S_CLR: begin
				cmd.clr_step = 1'b1;
				if (sts.clr_done) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_DISP;
				end
			end
			S_DISP: begin
				if (sts.bad) begin
					sel_d   = SEL_FAIL;
					state_d = S_EMIT;
				end else begin
					case (sts.func)
						FN_FREE: begin
							sel_d   = SEL_FREE;
							state_d = S_EMIT;
						end
						FN_QUERY: begin
							sel_d   = SEL_READ;
							state_d = S_QRD;
						end
						default: begin
							sel_d          = SEL_ALLOC;
							cmd.scan_start = 1'b1;
							state_d        = S_SCAN;
						end
					endcase
				end
			end
			S_QRD: begin
				state_d = S_EMIT;
			end
			S_SCAN: begin
				cmd.scan_issue = 1'b1;
				if (sts.scan_last) begin
					state_d = S_DRAIN;
				end
			end
			S_DRAIN: begin
				if (!sts.busy) begin
					state_d = S_EMIT;
				end
			end
			S_EMIT: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
			sel_q   <= SEL_FAIL;
		end else begin
			state_q <= state_d;
			sel_q   <= sel_d;
		end
	end

endmodule

@@ hw/rtl/pca_dp.sv @@
module pca_dp
	import pca_pkg::*;
#(
	parameter int MAPS    = 4,
	parameter int ENTRIES = 256
) (
	input  logic              clk,
	input  logic              arst_n,
	input  pca_cmd_t          cmd,
	output pca_sts_t          sts,
	input  logic [1:0]        func,
	input  logic [1:0]        map_index,
	input  logic [7:0]        pixel_index,
	input  logic [15:0]       req_red,
	input  logic [15:0]       req_green,
	input  logic [15:0]       req_blue,
	input  logic              cfg_we,
	input  logic [DIST_W-1:0] cfg_wdata,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [2:0]        status,
	output logic [7:0]        pixel,
	output logic [15:0]       out_red,
	output logic [15:0]       out_green,
	output logic [15:0]       out_blue
);

	localparam int MW    = (MAPS > 1) ? $clog2(MAPS) : 1;
	localparam int EW    = $clog2(ENTRIES);
	localparam int AW    = MW + EW;
	localparam int DEPTH = 1 << AW;
	localparam logic [EW-1:0] LAST_E = EW'(ENTRIES - 1);

	// Latched request.
	logic [1:0]  func_q;
	logic [1:0]  map_q;
	logic [7:0]  px_q;
	rgb_t        req_q;
	logic [DIST_W-1:0] near_q;

	// Palette storage: colors and used flags, one word per map and entry.
	rgb_t color_mem [DEPTH];
	logic used_mem  [DEPTH];

	logic [AW-1:0] clr_q;
	logic [EW-1:0] idx_q;
	logic [MW-1:0] map_sel;
	logic [AW-1:0] rd_addr;
	logic [AW-1:0] wr_addr;
	rgb_t          wr_color;
	logic          wr_used;
	logic          color_we;
	logic          used_we;

	// Scan pipeline.
	logic          valid_s1;
	logic [EW-1:0] entry_s1;
	rgb_t          rd_color_s1;
	logic          rd_used_s1;
	logic          valid_s2;
	logic [EW-1:0] entry_s2;
	logic          used_s2;
	logic          match_s2;
	logic [DIST_W-1:0] dist_s2;
	rgb_t          color_s2;

	// Scan results.
	logic              exact_found_q;
	logic              free_found_q;
	logic              near_found_q;
	logic [EW-1:0]     exact_e_q;
	logic [EW-1:0]     free_e_q;
	logic [EW-1:0]     best_e_q;
	logic [DIST_W-1:0] best_d_q;
	rgb_t              best_color_q;

	logic       add_now;
	logic [2:0] res_status;
	logic [7:0] res_pixel;
	rgb_t       res_color;
	logic       out_valid_q;

	assign map_sel = MW'(map_q);
	assign rd_addr = cmd.scan_issue ? {map_sel, idx_q} : {map_sel, px_q[EW-1:0]};

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			func_q <= func;
			map_q  <= map_index;
			px_q   <= pixel_index;
			req_q  <= '{req_red, req_green, req_blue};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			near_q <= NEAR_RESET;
		end else if (cfg_we) begin
			near_q <= cfg_wdata;
		end
	end

	// An allocation writes only when no exact match exists and a free entry was seen.
	assign add_now = cmd.emit && (cmd.sel == SEL_ALLOC) && !exact_found_q && free_found_q;

	always_comb begin
		wr_addr  = {map_sel, free_e_q};
		wr_color = req_q;
		wr_used  = 1'b1;
		color_we = 1'b0;
		used_we  = 1'b0;
		if (cmd.clr_step) begin
			wr_addr  = clr_q;
			wr_color = default_rgb(10'(clr_q[EW-1:0]), 10'(ENTRIES));
			wr_used  = default_used(10'(clr_q[EW-1:0]), 10'(ENTRIES));
			color_we = 1'b1;
			used_we  = 1'b1;
		end else if (cmd.emit && (cmd.sel == SEL_FREE)) begin
			wr_addr = {map_sel, px_q[EW-1:0]};
			wr_used = 1'b0;
			used_we = 1'b1;
		end else if (add_now) begin
			color_we = 1'b1;
			used_we  = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (color_we) begin
			color_mem[wr_addr] <= wr_color;
		end
		rd_color_s1 <= color_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (used_we) begin
			used_mem[wr_addr] <= wr_used;
		end
		rd_used_s1 <= used_mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q    <= '0;
			idx_q    <= '0;
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (cmd.clr_step) begin
				clr_q <= clr_q + AW'(1);
			end
			if (cmd.scan_start) begin
				idx_q <= '0;
			end else if (cmd.scan_issue) begin
				idx_q <= idx_q + EW'(1);
			end
			valid_s1 <= cmd.scan_issue;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		entry_s1 <= idx_q;
		entry_s2 <= entry_s1;
		used_s2  <= rd_used_s1;
		color_s2 <= rd_color_s1;
		match_s2 <= (rd_color_s1 == req_q);
		dist_s2  <= DIST_W'(absdiff16(rd_color_s1.r, req_q.r))
		          + DIST_W'(absdiff16(rd_color_s1.g, req_q.g))
		          + DIST_W'(absdiff16(rd_color_s1.b, req_q.b));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exact_found_q <= 1'b0;
			free_found_q  <= 1'b0;
			near_found_q  <= 1'b0;
		end else if (cmd.scan_start) begin
			exact_found_q <= 1'b0;
			free_found_q  <= 1'b0;
			near_found_q  <= 1'b0;
		end else if (valid_s2) begin
			if (used_s2 && match_s2) begin
				exact_found_q <= 1'b1;
			end
			if (!used_s2) begin
				free_found_q <= 1'b1;
			end
			if (used_s2) begin
				near_found_q <= 1'b1;
			end
		end
	end

	// The lowest entry wins every tie, since entries arrive in ascending order.
	always_ff @(posedge clk) begin
		if (valid_s2 && !cmd.scan_start) begin
			if (used_s2 && match_s2 && !exact_found_q) begin
				exact_e_q <= entry_s2;
			end
			if (!used_s2 && !free_found_q) begin
				free_e_q <= entry_s2;
			end
			if (used_s2 && (!near_found_q || (dist_s2 < best_d_q))) begin
				best_e_q     <= entry_s2;
				best_d_q     <= dist_s2;
				best_color_q <= color_s2;
			end
		end
	end

	always_comb begin
		res_status = ST_FAILED;
		res_pixel  = '0;
		res_color  = '0;
		case (cmd.sel)
			SEL_FREE: begin
				res_status = ST_FREED;
				res_pixel  = px_q;
			end
			SEL_READ: begin
				res_status = ST_READ;
				res_pixel  = px_q;
				res_color  = rd_color_s1;
			end
			SEL_ALLOC: begin
				if (exact_found_q) begin
					res_status = ST_EXACT;
					res_pixel  = 8'(exact_e_q);
					res_color  = req_q;
				end else if (free_found_q) begin
					res_status = ST_ADDED;
					res_pixel  = 8'(free_e_q);
					res_color  = req_q;
				end else if (near_found_q && (best_d_q < near_q)) begin
					res_status = ST_NEAREST;
					res_pixel  = 8'(best_e_q);
					res_color  = best_color_q;
				end
			end
			default: begin
				res_status = ST_FAILED;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			status    <= res_status;
			pixel     <= res_pixel;
			out_red   <= res_color.r;
			out_green <= res_color.g;
			out_blue  <= res_color.b;
		end
	end

	assign out_valid = out_valid_q;

	always_comb begin
		sts.clr_done  = &clr_q;
		sts.bad       = (int'(map_q) >= MAPS) || (func_q == 2'd3)
		              || ((func_q != FN_ALLOC) && (int'(px_q) >= ENTRIES));
		sts.func      = func_q;
		sts.scan_last = (idx_q == LAST_E);
		sts.busy      = valid_s1 || valid_s2;
		sts.out_free  = !out_valid_q || out_ready;
	end

	a_pipe_order: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> $past(valid_s1))
		else $error("scan stage 2 valid without stage 1");

	a_exact_kept: assert property (@(posedge clk) disable iff (!arst_n)
		(exact_found_q && !cmd.scan_start) |=> (exact_found_q && $stable(exact_e_q)))
		else $error("first exact match was overwritten during a scan");

	a_best_falls: assert property (@(posedge clk) disable iff (!arst_n)
		(near_found_q && $past(near_found_q) && !$past(cmd.scan_start))
		|-> (best_d_q <= $past(best_d_q)))
		else $error("nearest distance grew during a scan");

endmodule

@@ hw/rtl/palette_color_allocator.sv @@
// Channel   Dir  Handshake      Payload
// req       in   valid/ready    func, map_index, pixel_index, req_red, req_green, req_blue
// rsp       out  valid/ready    status, pixel, out_red, out_green, out_blue
// cfg       in   cfg_we only    cfg_wdata = near_limit
//
// For an allocate item the single read port of the palette memory walks every entry
// of the palette once. No item is taken before the last result is in the output register.
// After reset the palette memory is loaded with the default colors, one word per cycle,
// until every word of the memory is written; no item is taken then.
// A result waiting in the output register does not stop the next item from being taken.
module palette_color_allocator
	import pca_pkg::*;
#(
	parameter int MAPS    = 4,
	parameter int ENTRIES = 256
) (
	input  logic              clk,
	input  logic              arst_n,
	pca_req_if.sink           req,
	pca_rsp_if.source         rsp,
	input  logic              cfg_we,
	input  logic [DIST_W-1:0] cfg_wdata
);

	// The controller sequences each item through dispatch, the palette scan (for an
	// allocation) and the result handoff; the datapath owns the palette memory, the
	// two-stage scan pipeline that compares and measures every entry, and the output register.
	pca_cmd_t cmd;
	pca_sts_t sts;

	pca_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (req.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// During a scan the datapath keeps the first exact match, the first free entry
	// and the nearest used entry; the decision among them is taken when the item's
	// result is handed to the output register, which is also when a new color is
	// written into the claimed free entry.
	pca_dp #(
		.MAPS    (MAPS),
		.ENTRIES (ENTRIES)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.func        (req.func),
		.map_index   (req.map_index),
		.pixel_index (req.pixel_index),
		.req_red     (req.req_red),
		.req_green   (req.req_green),
		.req_blue    (req.req_blue),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.out_valid   (rsp.valid),
		.out_ready   (rsp.ready),
		.status      (rsp.status),
		.pixel       (rsp.pixel),
		.out_red     (rsp.out_red),
		.out_green   (rsp.out_green),
		.out_blue    (rsp.out_blue)
	);

endmodule
